/* hw/rtl/tlb_second_chance_fill_defines.svh */
// ----------------------------------------------------------------------------
// TLB second-chance fill: assertion macros
// Concurrent checks on clk with rst_n low masking; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TLB_SECOND_CHANCE_FILL_DEFINES_SVH
`define TLB_SECOND_CHANCE_FILL_DEFINES_SVH
`ifndef SYNTHESIS
`define TLBSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TLBSC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TLBSC_ASSERT(lbl, prop, msg)
`define TLBSC_NEVER(lbl, cond, msg)
`endif
`endif

/* hw/rtl/tlbsc_pkg.sv */
// ----------------------------------------------------------------------------
// TLB second-chance fill: shared package
// Command codes, record codes, default sizes and the front-to-back command.
// ----------------------------------------------------------------------------
package tlbsc_pkg;

  localparam int TLB_ENTRIES_DEF = 4;
  localparam int VPN_BITS_DEF    = 16;
  localparam int PPN_BITS_DEF    = 12;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input kind codes
  localparam logic [1:0] KIND_FILL  = 2'd0;
  localparam logic [1:0] KIND_TOUCH = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // result record codes
  localparam logic [1:0] REC_WRITEBACK = 2'd0;
  localparam logic [1:0] REC_PLACED    = 2'd1;
  localparam logic [1:0] REC_TOUCH_ACK = 2'd2;

  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_TOUCH = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  typedef struct packed {
    op_t  op;
    logic valid;
    logic used;
    logic dirty;
    logic read_only;
  } cmd_ctl_t;

endpackage

/* hw/rtl/tlbsc_front.sv */
// ----------------------------------------------------------------------------
// TLB second-chance fill: front end
// Accepts commands, drops unknown kinds, wraps the touch slot and queues
// the decoded command for the back end.
// ----------------------------------------------------------------------------
module tlbsc_front
  import tlbsc_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int VPN_BITS    = VPN_BITS_DEF,
  parameter int PPN_BITS    = PPN_BITS_DEF,
  localparam int SLOT_W     = $clog2(TLB_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_kind,
  input  logic [VPN_BITS-1:0] in_page_vpn,
  input  logic [PPN_BITS-1:0] in_page_ppn,
  input  logic                in_page_valid,
  input  logic                in_page_use,
  input  logic                in_page_dirty,
  input  logic                in_page_read_only,
  input  logic [1:0]          in_touch_slot,
  output logic                cmd_vld,
  output cmd_ctl_t            cmd_ctl,
  output logic [VPN_BITS-1:0] cmd_vpn,
  output logic [PPN_BITS-1:0] cmd_ppn,
  output logic [SLOT_W-1:0]   cmd_slot,
  input  logic                cmd_done
);

  cmd_ctl_t            q_ctl_r  [QUEUE_DEPTH];
  logic [VPN_BITS-1:0] q_vpn_r  [QUEUE_DEPTH];
  logic [PPN_BITS-1:0] q_ppn_r  [QUEUE_DEPTH];
  logic [SLOT_W-1:0]   q_slot_r [QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  cmd_ctl_t          dec_ctl;
  logic              dec_ok;
  logic [SLOT_W-1:0] dec_slot;
  logic              push;
  logic              pop;
  int                t;

  // classify
  always_comb begin
    dec_ok            = 1'b1;
    dec_ctl.op        = OP_FILL;
    dec_ctl.valid     = in_page_valid;
    dec_ctl.used      = in_page_use;
    dec_ctl.dirty     = in_page_dirty;
    dec_ctl.read_only = in_page_read_only;
    case (in_kind)
      KIND_FILL:  dec_ctl.op = OP_FILL;
      KIND_TOUCH: dec_ctl.op = OP_TOUCH;
      KIND_FLUSH: dec_ctl.op = OP_FLUSH;
      default:    dec_ok = 1'b0;
    endcase
  end

  // touch slot modulo the entry count; the value is below 4, two steps do it
  always_comb begin
    t = int'(in_touch_slot);
    if (t >= TLB_ENTRIES) t = t - TLB_ENTRIES;
    if (t >= TLB_ENTRIES) t = t - TLB_ENTRIES;
    dec_slot = SLOT_W'(t);
  end

  assign busy = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push = start && !busy && dec_ok;
  assign pop  = cmd_done && cmd_vld;

  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
  assign count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctl_r[wr_ptr_r]  <= dec_ctl;
      q_vpn_r[wr_ptr_r]  <= in_page_vpn;
      q_ppn_r[wr_ptr_r]  <= in_page_ppn;
      q_slot_r[wr_ptr_r] <= dec_slot;
    end
  end

  assign cmd_vld  = (count_r != '0);
  assign cmd_ctl  = q_ctl_r[rd_ptr_r];
  assign cmd_vpn  = q_vpn_r[rd_ptr_r];
  assign cmd_ppn  = q_ppn_r[rd_ptr_r];
  assign cmd_slot = q_slot_r[rd_ptr_r];

endmodule

/* hw/rtl/tlbsc_back.sv */
// ----------------------------------------------------------------------------
// TLB second-chance fill: back end
// Holds the TLB, runs fill / touch / flush on the queue head and emits one
// record per cycle while it works on a command.
// ----------------------------------------------------------------------------
`include "tlb_second_chance_fill_defines.svh"

module tlbsc_back
  import tlbsc_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int VPN_BITS    = VPN_BITS_DEF,
  parameter int PPN_BITS    = PPN_BITS_DEF,
  localparam int SLOT_W     = $clog2(TLB_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_vld,
  input  cmd_ctl_t            cmd_ctl,
  input  logic [VPN_BITS-1:0] cmd_vpn,
  input  logic [PPN_BITS-1:0] cmd_ppn,
  input  logic [SLOT_W-1:0]   cmd_slot,
  output logic                cmd_done,
  output logic                out_strobe,
  output logic [1:0]          out_record_kind,
  output logic [VPN_BITS-1:0] out_vpn,
  output logic                out_use,
  output logic                out_dirty,
  output logic [1:0]          out_slot,
  output logic                out_last
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SWEEP = 5'b00010,
    ST_PLACE = 5'b00100,
    ST_TOUCH = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t st_r, st_nxt;

  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [SLOT_W-1:0] sweep_ptr_r;
  logic [SLOT_W-1:0] cur_inc;
  logic [SLOT_W-1:0] first_free;
  logic              all_valid;
  logic              cur_is_end;

  logic [TLB_ENTRIES-1:0] valid_r;
  logic [TLB_ENTRIES-1:0] use_r;
  logic [TLB_ENTRIES-1:0] dirty_r;
  logic [TLB_ENTRIES-1:0] ro_r;
  logic [TLB_ENTRIES-1:0] wr_r;

  logic [VPN_BITS-1:0] vpn_mem [TLB_ENTRIES];
  logic [PPN_BITS-1:0] ppn_mem [TLB_ENTRIES];
  logic [VPN_BITS-1:0] rd_data_r;
  logic                rd_wr_r;
  logic [VPN_BITS-1:0] vpn_q;
  logic [SLOT_W+1:0]   slot_ext;

  assign all_valid  = &valid_r;
  assign cur_is_end = (cur_r == SLOT_W'(TLB_ENTRIES - 1));
  assign cur_inc    = cur_is_end ? '0 : cur_r + 1'b1;
  assign vpn_q      = rd_wr_r ? rd_data_r : '0;
  assign slot_ext   = {2'b00, cur_r};

  always_comb begin
    first_free = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) first_free = SLOT_W'(i);
    end
  end

  always_comb begin
    st_nxt          = st_r;
    cur_nxt         = cur_r;
    cmd_done        = 1'b0;
    out_strobe      = 1'b0;
    out_record_kind = REC_WRITEBACK;
    out_vpn         = vpn_q;
    out_use         = use_r[cur_r];
    out_dirty       = dirty_r[cur_r];
    out_slot        = slot_ext[1:0];
    out_last        = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (cmd_vld) begin
          case (cmd_ctl.op)
            OP_FILL: begin
              if (!all_valid) begin
                cur_nxt = first_free;
                st_nxt  = ST_PLACE;
              end else begin
                cur_nxt = sweep_ptr_r;
                st_nxt  = ST_SWEEP;
              end
            end
            OP_TOUCH: begin
              cur_nxt = cmd_slot;
              st_nxt  = ST_TOUCH;
            end
            OP_FLUSH: begin
              cur_nxt = '0;
              st_nxt  = ST_FLUSH;
            end
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        out_strobe = 1'b1;
        // used entry gets a second chance; unused one is the victim
        if (use_r[cur_r]) begin
          cur_nxt = cur_inc;
        end else begin
          st_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        out_strobe      = 1'b1;
        out_record_kind = REC_PLACED;
        out_vpn         = cmd_vpn;
        out_use         = cmd_ctl.used;
        out_dirty       = cmd_ctl.dirty;
        out_last        = 1'b1;
        cmd_done        = 1'b1;
        st_nxt          = ST_IDLE;
      end
      ST_TOUCH: begin
        out_strobe      = 1'b1;
        out_record_kind = REC_TOUCH_ACK;
        out_use         = 1'b1;
        out_dirty       = dirty_r[cur_r] | cmd_ctl.dirty;
        out_last        = 1'b1;
        cmd_done        = 1'b1;
        st_nxt          = ST_IDLE;
      end
      ST_FLUSH: begin
        out_strobe = 1'b1;
        out_last   = cur_is_end;
        if (cur_is_end) begin
          cmd_done = 1'b1;
          st_nxt   = ST_IDLE;
        end else begin
          cur_nxt = cur_inc;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cur_r       <= '0;
      sweep_ptr_r <= '0;
      valid_r     <= '0;
      use_r       <= '0;
      dirty_r     <= '0;
      ro_r        <= '0;
      wr_r        <= '0;
    end else begin
      st_r  <= st_nxt;
      cur_r <= cur_nxt;
      case (st_r)
        ST_SWEEP: begin
          if (use_r[cur_r]) begin
            use_r[cur_r] <= 1'b0;
          end else begin
            sweep_ptr_r <= cur_inc;
          end
        end
        ST_PLACE: begin
          valid_r[cur_r] <= cmd_ctl.valid;
          use_r[cur_r]   <= cmd_ctl.used;
          dirty_r[cur_r] <= cmd_ctl.dirty;
          ro_r[cur_r]    <= cmd_ctl.read_only;
          wr_r[cur_r]    <= 1'b1;
        end
        ST_TOUCH: begin
          use_r[cur_r] <= 1'b1;
          if (cmd_ctl.dirty) dirty_r[cur_r] <= 1'b1;
        end
        ST_FLUSH: begin
          if (cur_is_end) begin
            valid_r <= '0;
            use_r   <= '0;
            dirty_r <= '0;
            ro_r    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // page storage; the read port tracks the slot of the next cycle
  always_ff @(posedge clk) begin
    if (st_r == ST_PLACE) begin
      vpn_mem[cur_r] <= cmd_vpn;
      ppn_mem[cur_r] <= cmd_ppn;
    end
    rd_data_r <= vpn_mem[cur_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_wr_r <= 1'b0;
    end else begin
      rd_wr_r <= wr_r[cur_nxt];
    end
  end

  `TLBSC_ASSERT(a_sweep_only_when_full, (st_r == ST_SWEEP) |-> all_valid, "sweep with a free slot")
  `TLBSC_ASSERT(a_last_returns_idle, (out_strobe && out_last) |=> (st_r == ST_IDLE), "no idle after last beat")
  `TLBSC_ASSERT(a_flush_invalidates, (st_r == ST_FLUSH && out_last) |=> (valid_r == '0), "flush left a valid slot")
  `TLBSC_NEVER(a_done_without_cmd, cmd_done && !cmd_vld, "command done with empty queue")

endmodule

/* hw/rtl/tlb_second_chance_fill.sv */
// ----------------------------------------------------------------------------
// TLB second-chance fill: top level
// Self-replacing TLB with lowest-free-slot fill and clock-sweep eviction.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; commands wait in a
// two-entry queue and busy rises only when that queue is full. The TLB engine
// picks up the queue head in its idle state and then emits one record per
// cycle on out_strobe: a touch and a fill with a free slot give one record, a
// flush one per slot, and a fill that sweeps the clock one beat per visited
// slot, then the placed record. The record stream cannot be stalled: each
// record is valid for exactly the one cycle that out_strobe is high, and the
// last record of a command carries out_last. Commands of unknown kind are
// accepted and produce nothing.
module tlb_second_chance_fill
  import tlbsc_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int VPN_BITS    = VPN_BITS_DEF,
  parameter int PPN_BITS    = PPN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_kind,
  input  logic [VPN_BITS-1:0] in_page_vpn,
  input  logic [PPN_BITS-1:0] in_page_ppn,
  input  logic                in_page_valid,
  input  logic                in_page_use,
  input  logic                in_page_dirty,
  input  logic                in_page_read_only,
  input  logic [1:0]          in_touch_slot,
  output logic                out_strobe,
  output logic [1:0]          out_record_kind,
  output logic [VPN_BITS-1:0] out_vpn,
  output logic                out_use,
  output logic                out_dirty,
  output logic [1:0]          out_slot,
  output logic                out_last
);

  localparam int SLOT_W = $clog2(TLB_ENTRIES);

  logic                cmd_vld;
  cmd_ctl_t            cmd_ctl;
  logic [VPN_BITS-1:0] cmd_vpn;
  logic [PPN_BITS-1:0] cmd_ppn;
  logic [SLOT_W-1:0]   cmd_slot;
  logic                cmd_done;

  tlbsc_front #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .VPN_BITS    (VPN_BITS),
    .PPN_BITS    (PPN_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_page_vpn       (in_page_vpn),
    .in_page_ppn       (in_page_ppn),
    .in_page_valid     (in_page_valid),
    .in_page_use       (in_page_use),
    .in_page_dirty     (in_page_dirty),
    .in_page_read_only (in_page_read_only),
    .in_touch_slot     (in_touch_slot),
    .cmd_vld           (cmd_vld),
    .cmd_ctl           (cmd_ctl),
    .cmd_vpn           (cmd_vpn),
    .cmd_ppn           (cmd_ppn),
    .cmd_slot          (cmd_slot),
    .cmd_done          (cmd_done)
  );

  tlbsc_back #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .VPN_BITS    (VPN_BITS),
    .PPN_BITS    (PPN_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_vld         (cmd_vld),
    .cmd_ctl         (cmd_ctl),
    .cmd_vpn         (cmd_vpn),
    .cmd_ppn         (cmd_ppn),
    .cmd_slot        (cmd_slot),
    .cmd_done        (cmd_done),
    .out_strobe      (out_strobe),
    .out_record_kind (out_record_kind),
    .out_vpn         (out_vpn),
    .out_use         (out_use),
    .out_dirty       (out_dirty),
    .out_slot        (out_slot),
    .out_last        (out_last)
  );

endmodule

/* tb/sv/tb_tlb_second_chance_fill.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB second-chance fill: testbench
// Drives fill, touch, flush and unknown commands through the start/busy port,
// keeps its own copy of the TLB slots and clock pointer, and checks every
// record on the strobed result port field by field, in order. A short
// directed table runs first, then random traffic in phases of sender idling.
// ----------------------------------------------------------------------------
module tb_tlb_second_chance_fill;
  import tlbsc_pkg::*;

  localparam int VPN_W = VPN_BITS_DEF;
  localparam int PPN_W = PPN_BITS_DEF;
  localparam int SLOTS = TLB_ENTRIES_DEF;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam int ITEMS_PER_PHASE = 25;
  localparam int STALL_LIMIT     = 500;
  localparam int DRAIN_CYCLES    = 2 * (SLOTS + 3) + 4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [VPN_W-1:0] vpn;
    logic [PPN_W-1:0] ppn;
    logic             valid;
    logic             used;
    logic             dirty;
    logic             read_only;
    logic [1:0]       slot;
  } page_cmd_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [VPN_W-1:0] vpn;
    logic             used;
    logic             dirty;
    logic [1:0]       slot;
    logic             last;
  } tlb_record_t;

  typedef struct {
    page_cmd_t   cmd;
    bit          typed;
    tlb_record_t want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       in_kind = KIND_FILL;
  logic [VPN_W-1:0] in_page_vpn = '0;
  logic [PPN_W-1:0] in_page_ppn = '0;
  logic             in_page_valid = 1'b0;
  logic             in_page_use = 1'b0;
  logic             in_page_dirty = 1'b0;
  logic             in_page_read_only = 1'b0;
  logic [1:0]       in_touch_slot = 2'd0;
  logic             out_strobe;
  logic [1:0]       out_record_kind;
  logic [VPN_W-1:0] out_vpn;
  logic             out_use;
  logic             out_dirty;
  logic [1:0]       out_slot;
  logic             out_last;

  // shadow copy of the TLB
  bit [VPN_W-1:0] slot_vpn   [SLOTS];
  bit [PPN_W-1:0] slot_ppn   [SLOTS];
  bit             slot_valid [SLOTS];
  bit             slot_used  [SLOTS];
  bit             slot_dirty [SLOTS];
  bit             slot_ro    [SLOTS];
  int             clock_hand;

  tlb_record_t expected_records[$];
  tlb_record_t oldest_record;
  dir_row_t    dir_table[$];
  int          mismatches;
  int          quiet_cycles;

  tlb_second_chance_fill DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_page_vpn       (in_page_vpn),
    .in_page_ppn       (in_page_ppn),
    .in_page_valid     (in_page_valid),
    .in_page_use       (in_page_use),
    .in_page_dirty     (in_page_dirty),
    .in_page_read_only (in_page_read_only),
    .in_touch_slot     (in_touch_slot),
    .out_strobe        (out_strobe),
    .out_record_kind   (out_record_kind),
    .out_vpn           (out_vpn),
    .out_use           (out_use),
    .out_dirty         (out_dirty),
    .out_slot          (out_slot),
    .out_last          (out_last)
  );

  always #5 clk = ~clk;

  function automatic page_cmd_t mk_cmd(input logic [1:0] kind, input logic [VPN_W-1:0] vpn,
                                       input logic [PPN_W-1:0] ppn, input logic [3:0] flags,
                                       input logic [1:0] slot);
    page_cmd_t c;
    c.kind      = kind;
    c.vpn       = vpn;
    c.ppn       = ppn;
    c.read_only = flags[3];
    c.dirty     = flags[2];
    c.used      = flags[1];
    c.valid     = flags[0];
    c.slot      = slot;
    return c;
  endfunction

  function automatic tlb_record_t mk_rec(input logic [1:0] kind, input logic [VPN_W-1:0] vpn,
                                         input logic used, input logic dirty,
                                         input logic [1:0] slot, input logic last);
    tlb_record_t r;
    r.kind  = kind;
    r.vpn   = vpn;
    r.used  = used;
    r.dirty = dirty;
    r.slot  = slot;
    r.last  = last;
    return r;
  endfunction

  // Apply one accepted command to the shadow TLB and queue the records it causes.
  function automatic void predict_tlb_records(input page_cmd_t c);
    int  i;
    int  victim;
    int  p;
    bit  found;
    victim = 0;
    found  = 1'b0;
    case (c.kind)
      KIND_FILL: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!found && !slot_valid[i]) begin
            victim = i;
            found  = 1'b1;
          end
        end
        // all valid: sweep the clock, clearing use bits until an unused slot
        while (!found) begin
          p = clock_hand;
          if (slot_used[p]) begin
            slot_used[p] = 1'b0;
            expected_records.push_back(mk_rec(REC_WRITEBACK, slot_vpn[p], 1'b1,
                                              slot_dirty[p], p[1:0], 1'b0));
          end else begin
            expected_records.push_back(mk_rec(REC_WRITEBACK, slot_vpn[p], 1'b0,
                                              slot_dirty[p], p[1:0], 1'b0));
            victim = p;
            found  = 1'b1;
          end
          clock_hand = (p + 1) % SLOTS;
        end
        slot_vpn[victim]   = c.vpn;
        slot_ppn[victim]   = c.ppn;
        slot_valid[victim] = c.valid;
        slot_used[victim]  = c.used;
        slot_dirty[victim] = c.dirty;
        slot_ro[victim]    = c.read_only;
        expected_records.push_back(mk_rec(REC_PLACED, c.vpn, c.used, c.dirty,
                                          victim[1:0], 1'b1));
      end
      KIND_TOUCH: begin
        p = c.slot % SLOTS;
        slot_used[p] = 1'b1;
        if (c.dirty) slot_dirty[p] = 1'b1;
        expected_records.push_back(mk_rec(REC_TOUCH_ACK, slot_vpn[p], 1'b1, slot_dirty[p],
                                          p[1:0], 1'b1));
      end
      KIND_FLUSH: begin
        for (i = 0; i < SLOTS; i++) begin
          expected_records.push_back(mk_rec(REC_WRITEBACK, slot_vpn[i], slot_used[i],
                                            slot_dirty[i], i[1:0], i == SLOTS - 1));
        end
        // flags drop, vpn/ppn and the clock pointer stay
        for (i = 0; i < SLOTS; i++) begin
          slot_valid[i] = 1'b0;
          slot_used[i]  = 1'b0;
          slot_dirty[i] = 1'b0;
          slot_ro[i]    = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic page_cmd_t random_cmd();
    page_cmd_t c;
    int        pick;
    c = mk_cmd(KIND_FILL, VPN_W'($urandom), PPN_W'($urandom), 4'($urandom),
               2'($urandom_range(3)));
    pick = $urandom_range(99);
    if (pick < 45)      c.kind = KIND_FILL;
    else if (pick < 85) c.kind = KIND_TOUCH;
    else if (pick < 93) c.kind = KIND_FLUSH;
    else                c.kind = KIND_UNKNOWN;
    return c;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Present one command and hold it until the beat is taken; start stays high.
  task automatic drive_beat(input page_cmd_t c, input bit typed, input tlb_record_t want);
    bit was_busy;
    start             <= 1'b1;
    in_kind           <= c.kind;
    in_page_vpn       <= c.vpn;
    in_page_ppn       <= c.ppn;
    in_page_valid     <= c.valid;
    in_page_use       <= c.used;
    in_page_dirty     <= c.dirty;
    in_page_read_only <= c.read_only;
    in_touch_slot     <= c.slot;
    // sample busy mid-cycle so the edge decision is the one the block saw
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    predict_tlb_records(c);
    if (typed) expected_records[expected_records.size() - 1] = want;
  endtask

  task automatic send_cmd(input page_cmd_t c, input int idle_pct, input bit typed,
                          input tlb_record_t want);
    drive_beat(c, typed, want);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // result checker; records are stable mid-cycle
  always @(negedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual kind %0d vpn %0h slot %0d",
                 $time, out_record_kind, out_vpn, out_slot);
        mismatches++;
      end else begin
        oldest_record = expected_records.pop_front();
        check_field("record_kind", 32'(oldest_record.kind), 32'(out_record_kind));
        check_field("vpn", 32'(oldest_record.vpn), 32'(out_vpn));
        check_field("use", 32'(oldest_record.used), 32'(out_use));
        check_field("dirty", 32'(oldest_record.dirty), 32'(out_dirty));
        check_field("slot", 32'(oldest_record.slot), 32'(out_slot));
        check_field("last", 32'(oldest_record.last), 32'(out_last));
      end
    end
  end

  // watchdog: cycles with neither an accepted command nor a record
  always @(negedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d records still expected", $time,
                 expected_records.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int          phase;
    int          sent;
    int          idle_pct;
    page_cmd_t   c;
    tlb_record_t none;
    mismatches   = 0;
    quiet_cycles = 0;
    clock_hand   = 0;
    none         = '0;

    // touch of an invalid slot right after reset
    dir_table.push_back('{mk_cmd(KIND_TOUCH, 16'h0000, 12'h000, 4'b0100, 2'd3), 1'b1,
                          mk_rec(REC_TOUCH_ACK, 16'h0000, 1'b1, 1'b1, 2'd3, 1'b1)});
    dir_table.push_back('{mk_cmd(KIND_UNKNOWN, 16'hFFFF, 12'hFFF, 4'b1111, 2'd3), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_FILL, 16'hFFFF, 12'hFFF, 4'b1001, 2'd0), 1'b1,
                          mk_rec(REC_PLACED, 16'hFFFF, 1'b0, 1'b0, 2'd0, 1'b1)});
    // fill that leaves its slot invalid
    dir_table.push_back('{mk_cmd(KIND_FILL, 16'h0000, 12'h000, 4'b0110, 2'd0), 1'b1,
                          mk_rec(REC_PLACED, 16'h0000, 1'b1, 1'b1, 2'd1, 1'b1)});
    dir_table.push_back('{mk_cmd(KIND_FILL, 16'h1234, 12'hABC, 4'b0011, 2'd1), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_FILL, 16'h8000, 12'h800, 4'b0101, 2'd2), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_FILL, 16'h00AA, 12'h0AA, 4'b1111, 2'd3), 1'b0, none});
    // TLB full from here: sweeps
    dir_table.push_back('{mk_cmd(KIND_FILL, 16'h7FFF, 12'h7FF, 4'b0001, 2'd0), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_TOUCH, 16'hFFFF, 12'hFFF, 4'b1011, 2'd0), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_TOUCH, 16'h0000, 12'h000, 4'b0100, 2'd2), 1'b0, none});
    // every slot used: full lap plus the victim
    dir_table.push_back('{mk_cmd(KIND_FILL, 16'h5A5A, 12'h5A5, 4'b0011, 2'd1), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_TOUCH, 16'h0000, 12'h000, 4'b0000, 2'd3), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_TOUCH, 16'h0000, 12'h000, 4'b0100, 2'd1), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_FILL, 16'h0001, 12'h001, 4'b0001, 2'd0), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_FLUSH, 16'hFFFF, 12'hFFF, 4'b1111, 2'd3), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_FLUSH, 16'h0000, 12'h000, 4'b0000, 2'd0), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_TOUCH, 16'h0000, 12'h000, 4'b0000, 2'd2), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_FILL, 16'hFFFE, 12'hFFE, 4'b1110, 2'd2), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_UNKNOWN, 16'h0000, 12'h000, 4'b0000, 2'd0), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_TOUCH, 16'h0000, 12'h000, 4'b0100, 2'd0), 1'b0, none});
    dir_table.push_back('{mk_cmd(KIND_FLUSH, 16'h0000, 12'h000, 4'b0000, 2'd1), 1'b0, none});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      send_cmd(dir_table[i].cmd, (i % 3 == 0) ? 50 : 0, dir_table[i].typed,
               dir_table[i].want);
    end

    // sender idling per phase: none, heavy, none, light
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 56;
        3:       idle_pct = 26;
        default: idle_pct = 0;
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        c = random_cmd();
        send_cmd(c, idle_pct, 1'b0, none);
        if (c.kind != KIND_UNKNOWN) sent++;
      end
    end
    start <= 1'b0;

    while (expected_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/tlbsc_pkg.sv
hw/rtl/tlbsc_front.sv
hw/rtl/tlbsc_back.sv
hw/rtl/tlb_second_chance_fill.sv
tb/sv/tb_tlb_second_chance_fill.sv
